FILE: rtl/core/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: next-cycle check failed");

`endif

FILE: rtl/core/spq_pkg.sv
// Types and constants shared by the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int Capacity  = 16;
    localparam int CountW    = $clog2(Capacity + 1);
    localparam int OutCountW = 5;

    typedef enum logic {
        KindEnq = 1'b0,
        KindDeq = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        StOk    = 2'd0,
        StEmpty = 2'd1,
        StFull  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OpHold = 2'd0,
        OpEnq  = 2'd1,
        OpDeq  = 2'd2
    } t_op;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] item_value;
        logic [31:0] item_priority;
    } t_in_req;

    typedef struct packed {
        logic [31:0]          front_value;
        logic [31:0]          front_priority;
        logic [OutCountW-1:0] entry_count;
        logic                 is_empty;
        t_status              status;
    } t_out_req;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] prio;
    } t_entry;

    typedef struct packed {
        t_op    op;
        t_entry fresh;
    } t_cell_ctrl;

endpackage

FILE: rtl/core/spq_cell.sv
// One slot of the queue: holds an entry, shifts it toward either neighbor.
`timescale 1ns / 1ps
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_prev,
    input  spq_pkg::t_entry     i_next,
    input  logic                i_prev_keep,
    input  logic                i_occupied,
    output spq_pkg::t_entry     o_entry,
    output logic                o_keep
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    assign o_keep  = i_occupied &&
                     ($signed(r_entry.prio) >= $signed(i_ctrl.fresh.prio));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            spq_pkg::OpEnq: begin
                if (o_keep) begin
                    n_entry = r_entry;
                end else if (i_prev_keep) begin
                    n_entry = i_ctrl.fresh;
                end else begin
                    n_entry = i_prev;
                end
            end
            spq_pkg::OpDeq: begin
                n_entry = i_next;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell row, count and result register.
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"
// The queue keeps up to spq_pkg::Capacity value/priority pairs in a row of cells,
// front at cell 0, sorted by descending signed priority with ties in arrival order.
// For each request (enqueue or dequeue) every cell compares its priority with the
// incoming one in parallel and holds, loads the new pair, or takes its neighbor's
// entry, so a request can be accepted on every cycle unless the input stalls. The
// result (front pair, count, empty flag, status) reaches the output register in the
// cycle after acceptance; input stall follows only a full, stalled output register.
// Enqueue on a full queue is dropped and dequeue on an empty one is ignored.
module sorted_priority_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  spq_pkg::t_in_req i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output spq_pkg::t_out_req o_out
);

    localparam int Cap = spq_pkg::Capacity;
    localparam int CW  = spq_pkg::CountW;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    spq_pkg::t_out_req    r_out;
    spq_pkg::t_out_req    n_out;
    spq_pkg::t_cell_ctrl  w_ctrl;
    spq_pkg::t_entry      w_entry [Cap];
    logic                 w_keep  [Cap];
    spq_pkg::t_entry      n_front;
    spq_pkg::t_status     n_status;
    logic                 w_in_acc;
    logic                 w_full;
    logic                 w_empty;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CW'(Cap));
    assign w_empty     = (r_count == '0);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    genvar gi;
    generate
        for (gi = 0; gi < Cap; gi++) begin : g_cell
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_prev      ((gi == 0) ? w_ctrl.fresh : w_entry[(gi == 0) ? 0 : gi - 1]),
                .i_next      ((gi == Cap - 1) ? w_entry[gi]
                                              : w_entry[(gi == Cap - 1) ? gi : gi + 1]),
                .i_prev_keep ((gi == 0) ? 1'b1 : w_keep[(gi == 0) ? 0 : gi - 1]),
                .i_occupied  (CW'(gi) < r_count),
                .o_entry     (w_entry[gi]),
                .o_keep      (w_keep[gi])
            );
        end
    endgenerate

    always_comb begin
        w_ctrl.fresh.value = i_in.item_value;
        w_ctrl.fresh.prio  = i_in.item_priority;
        w_ctrl.op          = spq_pkg::OpHold;
        n_status           = spq_pkg::StOk;
        n_count            = r_count;
        if (i_in.kind == spq_pkg::KindEnq) begin
            if (w_full) begin
                n_status = spq_pkg::StFull;
            end else begin
                w_ctrl.op = spq_pkg::OpEnq;
                n_count   = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::StEmpty;
            end else begin
                w_ctrl.op = spq_pkg::OpDeq;
                n_count   = r_count - CW'(1);
            end
        end
        if (!w_in_acc) begin
            w_ctrl.op = spq_pkg::OpHold;
            n_count   = r_count;
        end
    end

    always_comb begin
        unique case (w_ctrl.op)
            spq_pkg::OpEnq: n_front = w_keep[0] ? w_entry[0] : w_ctrl.fresh;
            spq_pkg::OpDeq: n_front = w_entry[1];
            default:        n_front = w_entry[0];
        endcase

        n_out.is_empty    = (n_count == '0);
        n_out.front_value    = n_out.is_empty ? 32'd0 : n_front.value;
        n_out.front_priority = n_out.is_empty ? 32'd0 : n_front.prio;
        n_out.entry_count = spq_pkg::OutCountW'(n_count);
        n_out.status      = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= n_out;
        end
    end

    `SPQ_ASSERT_NOW(a_count_range, 1'b1, r_count <= CW'(Cap))
    `SPQ_ASSERT_NEXT(a_hold_count, w_in_acc && (w_ctrl.op == spq_pkg::OpHold), $stable(r_count))
    `SPQ_ASSERT_NOW(a_empty_zero, o_out_valid && o_out.is_empty,
                    (o_out.front_value == 32'd0) && (o_out.front_priority == 32'd0))
    `SPQ_ASSERT_NEXT(a_result_follows, w_in_acc, o_out_valid)

endmodule

FILE: test/sorted_priority_queue_test.sv
// Testbench for the sorted priority queue: directed table, then random requests.
`timescale 1ns / 1ps
module sorted_priority_queue_test;

    localparam int PlanRows    = 20;
    localparam int PhaseItems  = 275;
    localparam int DrainCycles = 10;

    typedef struct packed {
        spq_pkg::t_kind                kind;
        logic [31:0]                   value;
        logic [31:0]                   prio;
        logic                          typed;
        logic [31:0]                   want_value;
        logic [31:0]                   want_prio;
        logic [spq_pkg::OutCountW-1:0] want_count;
        logic                          want_empty;
        spq_pkg::t_status              want_status;
    } t_plan_row;

    localparam t_plan_row DirectedPlan [PlanRows] = '{
        '{spq_pkg::KindDeq, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'h0000_0000, 5'd0,  1'b1, spq_pkg::StEmpty},
        '{spq_pkg::KindEnq, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1,  1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h8000_0000, 32'h8000_0000,
          1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd2,  1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0001, 32'h7FFF_FFFF,
          1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd3,  1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0000, 32'h0000_0000,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0002, 32'h0000_0000,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0003, 32'h8000_0000,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0004, 32'h0000_0001,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0005, 32'hFFFF_FFFE,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0006, 32'h7FFF_FFFE,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0007, 32'h0000_0100,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0008, 32'h8000_0001,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_0009, 32'h5555_5555,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_000A, 32'hAAAA_AAAA,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_000B, 32'h0000_0000,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'h0000_000C, 32'h7FFF_FFFF,
          1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd16, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindEnq, 32'hDEAD_BEEF, 32'h7FFF_FFFF,
          1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd16, 1'b0, spq_pkg::StFull},
        '{spq_pkg::KindDeq, 32'h1234_5678, 32'h7FFF_FFFF,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk},
        '{spq_pkg::KindDeq, 32'hFFFF_FFFF, 32'h8000_0000,
          1'b0, 32'h0, 32'h0, 5'd0, 1'b0, spq_pkg::StOk}
    };

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    spq_pkg::t_in_req  in_req    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    spq_pkg::t_out_req out_result;

    int       send_idle_pct   = 0;
    int       recv_stall_pct  = 0;
    int       mismatch_count  = 0;

    logic [31:0]       queued_values [spq_pkg::Capacity];
    logic [31:0]       queued_prios  [spq_pkg::Capacity];
    int                queued_count  = 0;
    spq_pkg::t_out_req pending_results [$];

    sorted_priority_queue uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic spq_pkg::t_out_req advance_queue_model(spq_pkg::t_in_req req);
        spq_pkg::t_out_req outcome;
        int                pos;
        outcome.status = spq_pkg::StOk;
        if (req.kind == spq_pkg::KindEnq) begin
            if (queued_count >= spq_pkg::Capacity) begin
                outcome.status = spq_pkg::StFull;
            end else begin
                pos = 0;
                while (pos < queued_count &&
                       $signed(queued_prios[pos]) >= $signed(req.item_priority)) begin
                    pos++;
                end
                for (int i = queued_count; i > pos; i--) begin
                    queued_values[i] = queued_values[i-1];
                    queued_prios[i]  = queued_prios[i-1];
                end
                queued_values[pos] = req.item_value;
                queued_prios[pos]  = req.item_priority;
                queued_count++;
            end
        end else begin
            if (queued_count == 0) begin
                outcome.status = spq_pkg::StEmpty;
            end else begin
                for (int i = 0; i + 1 < queued_count; i++) begin
                    queued_values[i] = queued_values[i+1];
                    queued_prios[i]  = queued_prios[i+1];
                end
                queued_count--;
            end
        end
        outcome.is_empty       = (queued_count == 0);
        outcome.front_value    = outcome.is_empty ? 32'h0 : queued_values[0];
        outcome.front_priority = outcome.is_empty ? 32'h0 : queued_prios[0];
        outcome.entry_count    = spq_pkg::OutCountW'(queued_count);
        return outcome;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %h expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // hold the request until accepted, then record its outcome
    task automatic send_request(input spq_pkg::t_in_req req, input logic typed,
                                input spq_pkg::t_out_req want);
        spq_pkg::t_out_req predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_valid = 1'b0;
            in_req.kind          = spq_pkg::t_kind'($urandom_range(1));
            in_req.item_value    = $urandom;
            in_req.item_priority = $urandom;
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        in_req   = req;
        do @(posedge i_clk); while (in_stall);
        predicted = advance_queue_model(req);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        spq_pkg::t_out_req want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result front_value", out_result.front_value, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (out_result.front_value !== want.front_value)
                    report_mismatch("front_value", out_result.front_value, want.front_value);
                if (out_result.front_priority !== want.front_priority)
                    report_mismatch("front_priority", out_result.front_priority,
                                    want.front_priority);
                if (out_result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(out_result.entry_count),
                                    32'(want.entry_count));
                if (out_result.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(out_result.is_empty), 32'(want.is_empty));
                if (out_result.status !== want.status)
                    report_mismatch("status", 32'(out_result.status), 32'(want.status));
            end
        end
    end

    initial begin
        spq_pkg::t_in_req  req;
        spq_pkg::t_out_req want;
        bit                fill_bias;
        int                pick;
        fill_bias = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DirectedPlan[r]) begin
            req.kind            = DirectedPlan[r].kind;
            req.item_value      = DirectedPlan[r].value;
            req.item_priority   = DirectedPlan[r].prio;
            want.front_value    = DirectedPlan[r].want_value;
            want.front_priority = DirectedPlan[r].want_prio;
            want.entry_count    = DirectedPlan[r].want_count;
            want.is_empty       = DirectedPlan[r].want_empty;
            want.status         = DirectedPlan[r].want_status;
            send_request(req, DirectedPlan[r].typed, want);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int n = 0; n < PhaseItems; n++) begin
                // pick a random fill or drain bias every 40 requests to visit full and empty
                if (n % 40 == 0) fill_bias = $urandom_range(1);
                req.kind = ($urandom_range(99) < (fill_bias ? 80 : 25)) ?
                           spq_pkg::KindEnq : spq_pkg::KindDeq;
                req.item_value = $urandom;
                pick = $urandom_range(9);
                if (pick < 2)
                    req.item_priority = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                else if (pick < 6)
                    req.item_priority = 32'($signed($urandom_range(8)) - 4);
                else
                    req.item_priority = $urandom;
                send_request(req, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
test/sorted_priority_queue_test.sv
